### hw/rtl/bda_pkg.sv
package bda_pkg;

  // Field widths of the transfer ports.
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CHAR_W  = 6;

  // Number of decimal digits a 16-bit value can need, and the BCD word width.
  localparam int unsigned DIGITS   = 5;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned BCD_W    = DIGITS * DIGIT_W;
  localparam int unsigned IDX_W    = $clog2(DIGITS);
  localparam int unsigned CNT_W    = $clog2(VALUE_W);

  localparam logic [CNT_W-1:0]   LAST_SHIFT = CNT_W'(VALUE_W - 1);
  localparam logic [IDX_W-1:0]   TOP_DIGIT  = IDX_W'(DIGITS - 1);
  localparam logic [IDX_W-1:0]   LOW_DIGIT  = '0;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_OUT
  } seq_state_e;

  // Commands from the sequencer to the shift-and-add-3 unit.
  typedef struct packed {
    logic load;
    logic shift;
  } conv_ctrl_t;

endpackage

### hw/rtl/binary_to_decimal_ascii_top.sv
// Each value takes a load, 16 shift-and-add-3 steps and 5 digit scans; a new value is taken
// only in idle. It gives 1 to 5 characters, one per cycle; the receiver cannot stall the output.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops the strobe.
module binary_to_decimal_ascii_top
  import bda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  output logic               digit_valid_o,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               last_digit_o
);

  conv_ctrl_t       ctrl;
  logic [BCD_W-1:0] bcd;

  // Shift-and-add-3 unit.
  bda_conv u_conv (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .value_i (value_i),
    .bcd_o   (bcd)
  );

  // Sequencer and result register.
  bda_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .bcd_i         (bcd),
    .ctrl_o        (ctrl),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

endmodule

### hw/rtl/bda_conv.sv
module bda_conv
  import bda_pkg::*;
(
  input  logic               clk_i,
  input  conv_ctrl_t         ctrl_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic [BCD_W-1:0]   bcd_o
);

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   adj;

  // Add 3 to every BCD digit that is 5 or more, so the next shift carries.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Load a new value, or shift the adjusted BCD word and the binary word left.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
    end else if (ctrl_i.shift) begin
      {bcd_d, bin_d} = {adj[BCD_W-2:0], bin_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o = bcd_q;

endmodule

### hw/rtl/bda_seq.sv
module bda_seq
  import bda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [BCD_W-1:0]  bcd_i,
  output conv_ctrl_t        ctrl_o,
  output logic              digit_valid_o,
  output logic [CHAR_W-1:0] digit_char_o,
  output logic              last_digit_o
);

  seq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              started_q, started_d;
  logic              emit;
  logic              last;
  logic [DIGIT_W-1:0] digit;
  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  // Digit under scan, most significant first.
  assign digit = bcd_i[{idx_q, 2'b00} +: DIGIT_W];

  // Next state: load, sixteen shift steps, then a scan over the five digits.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    started_d = started_q;
    ctrl_o    = '0;
    emit      = 1'b0;
    last      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          cnt_d       = '0;
          state_d     = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        ctrl_o.shift = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == LAST_SHIFT) begin
          idx_d     = TOP_DIGIT;
          started_d = 1'b0;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        // Leading zeros are skipped; the units digit is always sent.
        last = (idx_q == LOW_DIGIT);
        if (digit != '0 || started_q || last) begin
          emit      = 1'b1;
          started_d = 1'b1;
        end
        if (last) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      started_q <= started_d;
      valid_q   <= emit;
    end
  end

  // Result register: each character is shown for one cycle with its strobe.
  always_ff @(posedge clk_i) begin
    char_q <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
    last_q <= last;
  end

  assign busy          = (state_q != ST_IDLE);
  assign digit_valid_o = valid_q;
  assign digit_char_o  = char_q;
  assign last_digit_o  = last_q;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bda_pkg::*;

  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned RANDOM_VALUES = 290;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_PRINTS    = 40;
  localparam int unsigned DIR_ROWS      = 22;
  localparam int unsigned TOP_PLACE     = 10000;
  localparam int unsigned DEC_BASE      = 10;

  // One expected character of a decimal run.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_exp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] value_i;
  logic               digit_valid_o;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_digit_o;

  digit_exp_t  digit_q[$];
  digit_exp_t  head_digit;
  int unsigned error_cnt     = 0;
  int unsigned values_sent   = 0;
  int unsigned chars_checked = 0;
  int unsigned drain_waits   = 0;
  int unsigned run_len       = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned runs_by_len[1:DIGITS];

  // Directed table: the decimal text is typed in where it is obvious, and
  // left empty where the predictor supplies the expected run.
  logic [VALUE_W-1:0] dir_val[DIR_ROWS] = '{
    16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
    16'd9999, 16'd10000, 16'd65535, 16'd32768, 16'd65534, 16'h5555,
    16'hAAAA, 16'h00FF, 16'hFF00, 16'd10203, 16'd60000, 16'd40001,
    16'd12345, 16'd7
  };
  string dir_dec[DIR_ROWS] = '{
    "0", "1", "9", "10", "99", "100", "999", "1000",
    "9999", "10000", "65535", "32768", "", "",
    "", "", "", "", "", "",
    "", ""
  };

  binary_to_decimal_ascii_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one line per mismatch and count it; printing stops after a while.
  task automatic report_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  // Queue the decimal run of a value: from typed text when given, otherwise by
  // long division with leading zeros dropped and the units digit always kept.
  function automatic void queue_decimal_run(input logic [VALUE_W-1:0] val,
                                            input string dec);
    int unsigned rest;
    int unsigned place;
    int unsigned dig;
    bit          leading;
    digit_exp_t  e;
    if (dec.len() != 0) begin
      for (int i = 0; i < dec.len(); i++) begin
        e.ch   = CHAR_W'(dec[i]);
        e.last = (i == dec.len() - 1);
        digit_q.push_back(e);
      end
    end else begin
      rest    = val;
      place   = TOP_PLACE;
      leading = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
        dig  = rest / place;
        rest = rest % place;
        if (dig != 0 || !leading || i == DIGITS - 1) begin
          leading = 1'b0;
          e.ch    = ASCII_ZERO + CHAR_W'(dig);
          e.last  = (i == DIGITS - 1);
          digit_q.push_back(e);
        end
        place = place / DEC_BASE;
      end
    end
  endfunction

  // Present a value and hold it until the start transfer happens.
  task automatic send_value(input logic [VALUE_W-1:0] val, input string dec);
    bit taken;
    @(negedge clk_i);
    start   = 1'b1;
    value_i = val;
    taken   = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    queue_decimal_run(val, dec);
    values_sent++;
  endtask

  // Drop start for a number of cycles, with noise on the value port.
  task automatic idle_cycles(input int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      start   = 1'b0;
      value_i = VALUE_W'($urandom);
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Stop sending until every queued character has come back.
  task automatic wait_for_empty();
    @(negedge clk_i);
    start = 1'b0;
    while (digit_q.size() != 0) @(negedge clk_i);
    drain_waits++;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Spread random values over every run length, plus some multiples of 100 with trailing zeros.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VALUE_W'($urandom_range(0, 9));
      1: return VALUE_W'($urandom_range(10, 99));
      2: return VALUE_W'($urandom_range(100, 999));
      3: return VALUE_W'($urandom_range(1000, 9999));
      4: return VALUE_W'($urandom_range(10000, 65535));
      5: return VALUE_W'($urandom_range(1, 655) * 100);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Check each character transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && digit_valid_o) begin
      if (digit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last=%0b",
                                  digit_char_o, last_digit_o));
      end else begin
        head_digit = digit_q.pop_front();
        if (digit_char_o !== head_digit.ch) begin
          report_mismatch($sformatf("digit_char %0d, expected %0d",
                                    digit_char_o, head_digit.ch));
        end
        if (last_digit_o !== head_digit.last) begin
          report_mismatch($sformatf("last_digit %0b, expected %0b",
                                    last_digit_o, head_digit.last));
        end
        chars_checked++;
      end
      run_len++;
      if (last_digit_o === 1'b1) begin
        if (run_len >= 1 && run_len <= DIGITS) begin
          runs_by_len[run_len]++;
        end
        run_len = 0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d characters outstanding.",
               cycle_cnt, digit_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random values with idling.
  initial begin
    logic [VALUE_W-1:0] rand_val;
    int unsigned        burst_left;
    burst_left = 0;
    for (int i = 1; i <= DIGITS; i++) runs_by_len[i] = 0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows go back to back so that start stays high across busy.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_value(dir_val[i], dir_dec[i]);
    end
    wait_for_empty();

    for (int n = 0; n < RANDOM_VALUES; n++) begin
      rand_val = pick_value();
      send_value(rand_val, "");
      if (burst_left == 0 && $urandom_range(0, 29) == 0) begin
        burst_left = $urandom_range(10, 25);
      end
      if ($urandom_range(0, 24) == 0) begin
        wait_for_empty();
      end else if (burst_left != 0) begin
        burst_left--;
      end else begin
        idle_cycles(pick_gap());
      end
    end

    wait_for_empty();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (digit_q.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", digit_q.size()));
    end

    $display("Converted %0d values (%0d from the directed table), %0d characters checked.",
             values_sent, DIR_ROWS, chars_checked);
    $display("Runs of 1..5 digits: %0d %0d %0d %0d %0d; %0d pauses until empty.",
             runs_by_len[1], runs_by_len[2], runs_by_len[3], runs_by_len[4],
             runs_by_len[5], drain_waits);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
